/* src/wcd_pkg.sv */
// Package for the window convergence detector.
// Holds field widths, defaults, request codes and register-map constants.
// Used by the request channel interface and all modules of the block.
package wcd_pkg;

	localparam int SAMPLE_W           = 32;
	localparam int TOL_W              = 16;
	localparam int DEF_WINDOW         = 5;
	localparam int DEF_VALUE_BITS     = 32;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic {
		REQ_PUSH  = 1'b0,
		REQ_CLEAR = 1'b1
	} req_kind_t;

	typedef enum logic {
		REG_TOLERANCE = 1'b0,
		REG_NONE      = 1'b1
	} reg_index_t;

endpackage

/* src/wcd_req_if.sv */
// Request and result channel interfaces of the window convergence detector.
// Valid/ready handshake with payload; depends on wcd_pkg.
interface wcd_req_if
	import wcd_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic signed [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output req_type, output sample_value, input ready);
	modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface

interface wcd_res_if;
	logic valid;
	logic ready;
	logic converged;

	modport source (output valid, output converged, input ready);
	modport sink   (input valid, input converged, output ready);
endinterface

/* src/wcd_spread_check.sv */
// All-pairs spread check over one window of values.
// Flags when every pair differs by at most the tolerance; depends on wcd_pkg.
module wcd_spread_check
	import wcd_pkg::*;
	#(
		parameter int WINDOW     = DEF_WINDOW,
		parameter int VALUE_BITS = DEF_VALUE_BITS
	) (
		input  logic signed [VALUE_BITS-1:0] vals [WINDOW],
		input  logic        [TOL_W-1:0]      tolerance,
		output logic                         all_close
	);

	localparam int DW = ((VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W) + 2;

	logic [WINDOW*WINDOW-1:0] pair_ok;
	logic signed [DW-1:0]     tol_ext;

	assign tol_ext = DW'({1'b0, tolerance});

	for (genvar i = 0; i < WINDOW; i++) begin : g_row
		for (genvar j = 0; j < WINDOW; j++) begin : g_col
			if (j > i) begin : g_pair
				logic signed [DW-1:0] a_ext;
				logic signed [DW-1:0] b_ext;
				logic signed [DW-1:0] diff;
				logic signed [DW-1:0] ndiff;
				assign a_ext = DW'(vals[i]);
				assign b_ext = DW'(vals[j]);
				assign diff  = a_ext - b_ext;
				assign ndiff = b_ext - a_ext;
				assign pair_ok[i*WINDOW+j] = (diff <= tol_ext) && (ndiff <= tol_ext);
			end else begin : g_skip
				assign pair_ok[i*WINDOW+j] = 1'b1;
			end
		end
	end

	assign all_close = &pair_ok;

endmodule

/* src/window_convergence_detector_core.sv */
// Top level of the window convergence detector: ring of recent values,
// fill count, tolerance register and result register.
// Depends on wcd_pkg, wcd_req_if/wcd_res_if and wcd_spread_check.
//
//  channel | role   | payload                    | handshake
//  --------+--------+----------------------------+-----------------------------
//  req     | sink   | req_type, sample_value     | valid/ready
//  res     | source | converged                  | valid/ready
//  apb     | slave  | tolerance at byte addr 0   | psel/penable, pready high
//
// One request per cycle sustained while the result is taken: the input register
// takes the request, then the result register takes the flag from the pair
// check when the input register advances.
// Reset clears ring position, fill count, tolerance (to 4) and valid flags.
// A stalled result holds in the result register; the input stage keeps
// accepting while the result register can take its item.
module window_convergence_detector_core
	import wcd_pkg::*;
	#(
		parameter int WINDOW     = DEF_WINDOW,
		parameter int VALUE_BITS = DEF_VALUE_BITS
	) (
		input  logic                  clk,
		input  logic                  arst_n,
		input  logic                  psel,
		input  logic                  penable,
		input  logic                  pwrite,
		input  logic [APB_ADDR_W-1:0] paddr,
		input  logic [APB_DATA_W-1:0] pwdata,
		output logic [APB_DATA_W-1:0] prdata,
		output logic                  pready,
		wcd_req_if.sink               req,
		wcd_res_if.source             res
	);

	localparam int POS_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);

	logic [TOL_W-1:0] tolerance_q;
	reg_index_t       reg_sel;

	logic                         s1_valid;
	logic                         s1_clear;
	logic signed [VALUE_BITS-1:0] s1_value;
	logic signed [VALUE_BITS-1:0] in_value;

	logic signed [VALUE_BITS-1:0] store_q [WINDOW];
	logic signed [VALUE_BITS-1:0] win     [WINDOW];
	logic [POS_W-1:0]             pos_q;
	logic [CNT_W-1:0]             fill_q;

	logic res_valid_q;
	logic converged_q;
	logic advance;
	logic all_close;
	logic full_next;

	assign reg_sel = reg_index_t'(paddr[2]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_sel)
			REG_TOLERANCE: prdata = APB_DATA_W'(tolerance_q);
			REG_NONE:      prdata = '0;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_TOLERANCE) begin
			tolerance_q <= pwdata[TOL_W-1:0];
		end
	end

	if (VALUE_BITS <= SAMPLE_W) begin : g_narrow
		assign in_value = req.sample_value[VALUE_BITS-1:0];
	end else begin : g_wide
		assign in_value = {{(VALUE_BITS-SAMPLE_W){req.sample_value[SAMPLE_W-1]}},
			req.sample_value};
	end

	assign advance   = s1_valid && (!res_valid_q || res.ready);
	assign req.ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req.ready) begin
			s1_valid <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			s1_clear <= (req.req_type == REQ_CLEAR);
			s1_value <= in_value;
		end
	end

	always_comb begin
		for (int k = 0; k < WINDOW; k++) begin
			win[k] = (pos_q == POS_W'(k)) ? s1_value : store_q[k];
		end
	end

	wcd_spread_check #(
		.WINDOW     (WINDOW),
		.VALUE_BITS (VALUE_BITS)
	) u_spread (
		.vals      (win),
		.tolerance (tolerance_q),
		.all_close (all_close)
	);

	assign full_next = (fill_q >= CNT_W'(WINDOW - 1));

	always_ff @(posedge clk) begin
		for (int k = 0; k < WINDOW; k++) begin
			if (advance && !s1_clear && pos_q == POS_W'(k)) begin
				store_q[k] <= s1_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (advance) begin
			if (s1_clear) begin
				pos_q  <= '0;
				fill_q <= '0;
			end else begin
				pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
				if (fill_q < CNT_W'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			converged_q <= !s1_clear && full_next && all_close;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.converged = converged_q;

endmodule
